FILE: sv/klfr_pkg.sv
// shared types, codes and decode helpers of the keypad link frame receiver
package klfr_pkg;

    // frame framing and type bytes
    localparam logic [7:0] SOF_BYTE   = 8'h55;
    localparam logic [7:0] EOF_BYTE   = 8'hAA;
    localparam logic [7:0] T_KEYDOWN  = 8'h10;
    localparam logic [7:0] T_KEYUP    = 8'h11;
    localparam logic [7:0] T_HEART    = 8'h20;
    localparam logic [7:0] T_SPEED    = 8'h30;
    localparam logic [7:0] T_LINK     = 8'h22;
    localparam logic [7:0] NO_KEY     = 8'hFF;

    // key data codes with special meaning
    localparam logic [7:0] KD_START   = 8'h01;
    localparam logic [7:0] KD_STOP    = 8'h02;

    localparam logic [15:0] WD_LIMIT_RESET = 16'd30;

    // operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // machine states
    localparam logic [2:0] MS_SETTING   = 3'd2;
    localparam logic [2:0] MS_RUNNING   = 3'd3;
    localparam logic [2:0] MS_COUNTDOWN = 3'd4;
    localparam logic [2:0] MS_ERROR     = 3'd5;

    // result actions
    localparam logic [2:0] ACT_KEY    = 3'd0;
    localparam logic [2:0] ACT_HEART  = 3'd1;
    localparam logic [2:0] ACT_SPEED  = 3'd2;
    localparam logic [2:0] ACT_HOTKEY = 3'd3;
    localparam logic [2:0] ACT_WDOG   = 3'd4;

    // key ids
    localparam logic [2:0] KEY_ONOFF  = 3'd0;
    localparam logic [2:0] KEY_UP     = 3'd1;
    localparam logic [2:0] KEY_DOWN   = 3'd2;
    localparam logic [2:0] KEY_MODE   = 3'd3;
    localparam logic [2:0] KEY_PROG   = 3'd4;
    localparam logic [2:0] KEY_NONE   = 3'd7;

    // key events
    localparam logic [1:0] EVT_PRESS   = 2'd0;
    localparam logic [1:0] EVT_HOLD    = 2'd1;
    localparam logic [1:0] EVT_RELEASE = 2'd2;

    localparam logic [7:0] HOTKEY_MIN = 8'd20;
    localparam logic [7:0] HOTKEY_MAX = 8'd120;

    typedef enum logic [2:0] {
        P_HUNT  = 3'd0,
        P_TYPE  = 3'd1,
        P_DATA  = 3'd2,
        P_CHECK = 3'd3,
        P_END   = 3'd4
    } t_phase;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic [2:0] machine_state;
        logic       safety_lock_error;
        logic       wd_enable;
    } t_item;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] key_id;
        logic [1:0] key_event;
        logic [7:0] value;
        logic       beep;
        logic       watchdog_expired;
        logic       last;
    } t_result;

    function automatic t_result mk_res(input logic [2:0] action, input logic [2:0] key_id,
                                       input logic [1:0] key_event, input logic [7:0] value,
                                       input logic beep, input logic expired);
        t_result r;
        r.action           = action;
        r.key_id           = key_id;
        r.key_event        = key_event;
        r.value            = value;
        r.beep             = beep;
        r.watchdog_expired = expired;
        r.last             = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] key_of(input logic [7:0] d);
        logic [2:0] k;
        case (d)
            8'h03, 8'h07: k = KEY_UP;
            8'h04, 8'h08: k = KEY_DOWN;
            8'h05:        k = KEY_MODE;
            8'h06:        k = KEY_PROG;
            default:      k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_speed_key(input logic [7:0] d);
        return (d == 8'h03) || (d == 8'h04) || (d == 8'h07) || (d == 8'h08);
    endfunction

    function automatic logic [7:0] hotkey_speed(input logic [7:0] d);
        logic [7:0] s;
        case (d)
            8'h0D:   s = 8'd20;
            8'h09:   s = 8'd40;
            8'h0E:   s = 8'd50;
            8'h0A:   s = 8'd60;
            8'h0B:   s = 8'd80;
            8'h0C:   s = 8'd100;
            8'h0F:   s = 8'd120;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/keypad_link_frame_receiver.sv
// top level of the keypad link frame receiver
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_operation i_rx_byte i_machine_state
//                                            i_safety_lock_error i_wd_enable
//  result    out        o_valid / i_ready    o_action o_key_id o_key_event o_value
//                                            o_beep o_watchdog_expired o_last
//  config    in         i_cfg_we             i_cfg_data (watchdog limit)
//
// a transaction goes into the input register, is decoded from it and its results land
// in a two-entry result queue. the single result port drains the queue one result per
// cycle while i_ready is high; a new transaction is taken as the held one commits.
// synchronous active-low reset clears the parser, held key, watchdog count and queue.
// a stall on the result side holds the decoded item in the input register until the
// queue has room for all of its results; o_ready stays low meanwhile.
module keypad_link_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_machine_state,
    input  logic        i_safety_lock_error,
    input  logic        i_wd_enable,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [2:0]  o_key_id,
    output logic [1:0]  o_key_event,
    output logic [7:0]  o_value,
    output logic        o_beep,
    output logic        o_watchdog_expired,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    // watchdog limit register
    logic [15:0] r_wd_limit;

    // input register
    logic              r_in_valid;
    klfr_pkg::t_item   r_item;
    klfr_pkg::t_item   in_item;

    // decode results and queue status
    klfr_pkg::t_result res0, res1, head;
    logic [1:0]        res_cnt;
    logic [1:0]        q_cnt;
    logic [1:0]        q_space;
    logic              pop;
    logic              fire;

    assign in_item.operation         = i_operation;
    assign in_item.rx_byte           = i_rx_byte;
    assign in_item.machine_state     = i_machine_state;
    assign in_item.safety_lock_error = i_safety_lock_error;
    assign in_item.wd_enable         = i_wd_enable;

    // queue room counts the entry leaving this cycle
    assign pop     = o_valid && i_ready;
    assign q_space = 2'd2 - q_cnt + {1'b0, pop};
    // held item commits once all of its results fit
    assign fire    = r_in_valid && (res_cnt <= q_space);
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wd_limit <= klfr_pkg::WD_LIMIT_RESET;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (i_cfg_we) r_wd_limit <= i_cfg_data;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_item <= in_item;
    end

    klfr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (r_item),
        .i_fire     (fire),
        .i_wd_limit (r_wd_limit),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_res_cnt  (res_cnt)
    );

    klfr_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_push_cnt (fire ? res_cnt : 2'd0),
        .i_pop      (pop),
        .o_head     (head),
        .o_cnt      (q_cnt)
    );

    assign o_valid            = (q_cnt != 2'd0);
    assign o_action           = head.action;
    assign o_key_id           = head.key_id;
    assign o_key_event        = head.key_event;
    assign o_value            = head.value;
    assign o_beep             = head.beep;
    assign o_watchdog_expired = head.watchdog_expired;
    assign o_last             = head.last;

endmodule

FILE: sv/klfr_core.sv
// frame parser, key event logic and link watchdog with their state registers
module klfr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  klfr_pkg::t_item   i_item,
    input  logic              i_fire,
    input  logic [15:0]       i_wd_limit,
    output klfr_pkg::t_result o_res0,
    output klfr_pkg::t_result o_res1,
    output logic [1:0]        o_res_cnt
);

    klfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_payload, n_payload;
    logic [7:0]  r_held, n_held;
    logic        r_shs, n_shs;
    logic [15:0] r_silence, n_silence;

    logic frame_ok;

    assign frame_ok = (i_item.operation == klfr_pkg::OP_BYTE) && (r_phase == klfr_pkg::P_END)
                    && (i_item.rx_byte == klfr_pkg::EOF_BYTE);

    // parse phase next state
    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_payload = r_payload;
        if (i_item.operation == klfr_pkg::OP_BYTE) begin
            case (r_phase)
                klfr_pkg::P_HUNT: begin
                    if (i_item.rx_byte == klfr_pkg::SOF_BYTE) n_phase = klfr_pkg::P_TYPE;
                end
                klfr_pkg::P_TYPE: begin
                    n_kind  = i_item.rx_byte;
                    n_phase = klfr_pkg::P_DATA;
                end
                klfr_pkg::P_DATA: begin
                    n_payload = i_item.rx_byte;
                    n_phase   = klfr_pkg::P_CHECK;
                end
                klfr_pkg::P_CHECK: begin
                    n_phase = ((r_kind ^ r_payload) == i_item.rx_byte) ? klfr_pkg::P_END
                                                                       : klfr_pkg::P_HUNT;
                end
                default: n_phase = klfr_pkg::P_HUNT;
            endcase
        end
    end

    // results, key state and watchdog
    always_comb begin
        logic [7:0]  d;
        logic [2:0]  ms;
        logic [2:0]  id;
        logic [7:0]  hk;
        logic        running;
        logic        rel;
        logic        press;
        logic [15:0] sil_inc;
        klfr_pkg::t_result r0;
        klfr_pkg::t_result r1;
        logic [1:0]  cnt;

        d       = r_payload;
        ms      = i_item.machine_state;
        id      = klfr_pkg::key_of(d);
        hk      = klfr_pkg::hotkey_speed(d);
        running = (ms == klfr_pkg::MS_RUNNING);
        rel     = 1'b0;
        press   = 1'b0;
        sil_inc = (r_silence < i_wd_limit) ? r_silence + 16'd1 : r_silence;
        r0      = '0;
        r1      = '0;
        cnt     = 2'd0;
        n_held    = r_held;
        n_shs     = r_shs;
        n_silence = r_silence;

        if (i_item.operation == klfr_pkg::OP_TICK) begin
            if (!i_item.wd_enable) begin
                n_silence = 16'd0;
                r0 = klfr_pkg::mk_res(klfr_pkg::ACT_WDOG, 3'd0, 2'd0, 8'd0, 1'b0, 1'b0);
            end else begin
                n_silence = sil_inc;
                r0 = klfr_pkg::mk_res(klfr_pkg::ACT_WDOG, 3'd0, 2'd0, 8'd0, 1'b0,
                                      sil_inc >= i_wd_limit);
            end
            cnt = 2'd1;
        end else if (frame_ok) begin
            n_silence = 16'd0;
            if (r_kind == klfr_pkg::T_LINK) begin
                // link ping only feeds the watchdog
            end else if (ms == klfr_pkg::MS_ERROR && i_item.safety_lock_error) begin
                // safety lock blocks every command
            end else if (r_kind == klfr_pkg::T_HEART) begin
                r0  = klfr_pkg::mk_res(klfr_pkg::ACT_HEART, 3'd0, 2'd0, d, 1'b0, 1'b0);
                cnt = 2'd1;
            end else if (r_kind == klfr_pkg::T_SPEED) begin
                r0     = klfr_pkg::mk_res(klfr_pkg::ACT_SPEED, 3'd0, 2'd0, d, 1'b0, 1'b0);
                cnt    = 2'd1;
                n_held = klfr_pkg::NO_KEY;
            end else if (r_kind == klfr_pkg::T_KEYDOWN) begin
                if (d == klfr_pkg::KD_START) begin
                    if (ms <= klfr_pkg::MS_SETTING) begin
                        r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, klfr_pkg::KEY_ONOFF,
                                               klfr_pkg::EVT_PRESS, 8'd0, 1'b0, 1'b0);
                        cnt = 2'd1;
                    end
                    n_held = klfr_pkg::NO_KEY;
                end else if (d == klfr_pkg::KD_STOP) begin
                    if (ms == klfr_pkg::MS_RUNNING || ms == klfr_pkg::MS_COUNTDOWN) begin
                        r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, klfr_pkg::KEY_ONOFF,
                                               klfr_pkg::EVT_PRESS, 8'd0, 1'b0, 1'b0);
                        cnt = 2'd1;
                    end
                    n_held = klfr_pkg::NO_KEY;
                end else if (hk != 8'd0) begin
                    // hotkeys 0x09 to 0x0c come with a click
                    r0 = klfr_pkg::mk_res(klfr_pkg::ACT_HOTKEY, 3'd0, 2'd0, hk,
                                          (d >= 8'h09) && (d <= 8'h0C), 1'b0);
                    cnt    = 2'd1;
                    n_held = klfr_pkg::NO_KEY;
                end else if (id == klfr_pkg::KEY_NONE) begin
                    // unknown key data is ignored
                end else if (d == r_held) begin
                    r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_HOLD,
                                           8'd0, 1'b0, 1'b0);
                    cnt = 2'd1;
                    if (klfr_pkg::is_speed_key(d)) n_shs = 1'b1;
                end else begin
                    rel   = (r_held != klfr_pkg::NO_KEY)
                         && (klfr_pkg::key_of(r_held) != klfr_pkg::KEY_NONE);
                    press = !(running && klfr_pkg::is_speed_key(d));
                    if (rel) begin
                        r0 = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, klfr_pkg::key_of(r_held),
                                              klfr_pkg::EVT_RELEASE, 8'd0, 1'b0, 1'b0);
                        r1 = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_PRESS,
                                              8'd0, 1'b0, 1'b0);
                        cnt = press ? 2'd2 : 2'd1;
                    end else begin
                        r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_PRESS,
                                               8'd0, 1'b0, 1'b0);
                        cnt = press ? 2'd1 : 2'd0;
                    end
                    n_held = d;
                    // speed key press while running waits for hold or release
                    if (!press) n_shs = 1'b0;
                end
            end else if (r_kind == klfr_pkg::T_KEYUP) begin
                if (d == klfr_pkg::KD_START || d == klfr_pkg::KD_STOP || hk != 8'd0) begin
                    n_held = klfr_pkg::NO_KEY;
                end else if (id != klfr_pkg::KEY_NONE && d == r_held) begin
                    // deferred press goes out ahead of the release
                    if (running && klfr_pkg::is_speed_key(d) && !r_shs) begin
                        r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_PRESS,
                                               8'd0, 1'b0, 1'b0);
                        r1  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_RELEASE,
                                               8'd0, 1'b0, 1'b0);
                        cnt = 2'd2;
                    end else begin
                        r0  = klfr_pkg::mk_res(klfr_pkg::ACT_KEY, id, klfr_pkg::EVT_RELEASE,
                                               8'd0, 1'b0, 1'b0);
                        cnt = 2'd1;
                    end
                    n_held = klfr_pkg::NO_KEY;
                    n_shs  = 1'b0;
                end
            end
        end

        if (cnt == 2'd1) r0.last = 1'b1;
        if (cnt == 2'd2) r1.last = 1'b1;
        o_res0    = r0;
        o_res1    = r1;
        o_res_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= klfr_pkg::P_HUNT;
            r_kind    <= 8'd0;
            r_payload <= 8'd0;
            r_held    <= klfr_pkg::NO_KEY;
            r_shs     <= 1'b0;
            r_silence <= 16'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_payload <= n_payload;
            r_held    <= n_held;
            r_shs     <= n_shs;
            r_silence <= n_silence;
        end
    end

endmodule

FILE: sv/klfr_outq.sv
// two-entry result queue, takes up to two results a cycle and drains one
module klfr_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  klfr_pkg::t_result i_res0,
    input  klfr_pkg::t_result i_res1,
    input  logic [1:0]        i_push_cnt,
    input  logic              i_pop,
    output klfr_pkg::t_result o_head,
    output logic [1:0]        o_cnt
);

    klfr_pkg::t_result r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        klfr_pkg::t_result s0;
        logic [1:0] c1;
        s0 = i_pop ? r_q1 : r_q0;
        c1 = r_cnt - {1'b0, i_pop};
        n_q0 = s0;
        n_q1 = r_q1;
        if (i_push_cnt != 2'd0) begin
            if (c1 == 2'd0) begin
                n_q0 = i_res0;
                n_q1 = i_res1;
            end else begin
                n_q1 = i_res0;
            end
        end
        n_cnt = c1 + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_head = r_q0;
    assign o_cnt  = r_cnt;

endmodule

FILE: sv/klfr_checker.sv
// port-level checks of the keypad link frame receiver, bound to the top level
module klfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_action,
    input logic [2:0]  o_key_id,
    input logic [1:0]  o_key_event,
    input logic [7:0]  o_value,
    input logic        o_beep,
    input logic        o_watchdog_expired,
    input logic        o_last
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action) && $stable(o_value)
                                && $stable(o_last))
        else $error("stalled result changed");

    // watchdog status is a lone result with no other fields set
    a_wdog_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == klfr_pkg::ACT_WDOG |->
            o_last && o_key_id == 3'd0 && o_value == 8'd0 && !o_beep)
        else $error("malformed watchdog result");

    // expiry only comes with watchdog status
    a_expired_only_wdog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action != klfr_pkg::ACT_WDOG |-> !o_watchdog_expired)
        else $error("expiry flag on non-watchdog result");

    // hotkey speed within its table range and single
    a_hotkey_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == klfr_pkg::ACT_HOTKEY |->
            o_value >= klfr_pkg::HOTKEY_MIN && o_value <= klfr_pkg::HOTKEY_MAX && o_last
            && o_key_event == klfr_pkg::EVT_PRESS)
        else $error("hotkey result out of range");

endmodule

bind keypad_link_frame_receiver klfr_checker u_klfr_checker (.*);
